// File: rtl/core/robust_depth_trimmed_mean_core_macros.svh
// Assertion macros for the robust depth trimmed-mean core.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef ROBUST_DEPTH_TRIMMED_MEAN_CORE_MACROS_SVH
`define ROBUST_DEPTH_TRIMMED_MEAN_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RDTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdtm assertion failed");

// Next-cycle implication, checked outside reset.
`define RDTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdtm assertion failed");

`else

`define RDTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RDTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/rdtm_pkg.sv
// Package for the robust depth trimmed-mean core: widths, beat types and
// the compare-exchange helpers of the sorting network. Depends on nothing.
package rdtm_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int WINDOW_SIZE     = 9;
    localparam int COUNT_BITS      = 4;
    localparam int DEPTH_BITS      = 16;
    localparam int FRAC_BITS       = 8;
    localparam int PAIR_TOL_BITS   = 9;
    localparam int TRIPLE_TOL_BITS = 10;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 32;

    localparam logic [PAIR_TOL_BITS-1:0]   PAIR_TOL_RESET   = PAIR_TOL_BITS'(5);
    localparam logic [TRIPLE_TOL_BITS-1:0] TRIPLE_TOL_RESET = TRIPLE_TOL_BITS'(7);

    // A sum of up to three pixels, and its compare width against a tolerance.
    localparam int SUM_BITS = PIXEL_BITS + 2;
    localparam int CMP_BITS = (SUM_BITS > TRIPLE_TOL_BITS) ? SUM_BITS : TRIPLE_TOL_BITS;

    // Reciprocal of three: floor(x * RECIP / 2^RECIP_SHIFT) is x/3 or one less.
    localparam int RECIP_SHIFT = SUM_BITS + 1;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((2 ** RECIP_SHIFT) / 3);

    // Fraction of one third and two thirds in the output format.
    localparam logic [FRAC_BITS-1:0] THIRD_FRAC     = FRAC_BITS'((2 ** FRAC_BITS) / 3);
    localparam logic [FRAC_BITS-1:0] TWO_THIRD_FRAC = FRAC_BITS'((2 ** (FRAC_BITS + 1)) / 3);

    // Register indexes on the configuration port (address bit 2).
    localparam logic REG_PAIR_TOL   = 1'b0;
    localparam logic REG_TRIPLE_TOL = 1'b1;

    typedef logic [PIXEL_BITS-1:0]  pixel_t;
    typedef pixel_t [WINDOW_SIZE-1:0] window_t;

    typedef struct packed {
        pixel_t                pixel_0;
        pixel_t                pixel_1;
        pixel_t                pixel_2;
        pixel_t                pixel_3;
        pixel_t                pixel_4;
        pixel_t                pixel_5;
        pixel_t                pixel_6;
        pixel_t                pixel_7;
        pixel_t                pixel_8;
        logic [COUNT_BITS-1:0] window_count;
        pixel_t                center_value;
    } win_beat_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth_fixed;
        logic                  kept_center;
    } res_beat_t;

    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_PAIR,
        MODE_TRIPLE
    } mode_t;

    // One layer of odd-even transposition: independent compare-exchanges.
    function automatic window_t sort_layer(window_t w, logic odd);
        window_t r;
        int      a;
        r = w;
        for (int i = 0; i < (WINDOW_SIZE - 1) / 2; i++) begin
            a = 2 * i + int'(odd);
            if (w[a] > w[a + 1]) begin
                r[a]     = w[a + 1];
                r[a + 1] = w[a];
            end
        end
        return r;
    endfunction

    // True when the window is in ascending order.
    function automatic logic is_sorted(window_t w);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
            if (w[i] > w[i + 1]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: rtl/core/robust_depth_trimmed_mean_core.sv
// Robust depth trimmed-mean core: six-stage pipeline from an accepted window beat
// to its result beat; one beat per cycle sustained unless the result channel stalls.
// Stages: three sort stages of three compare layers each, entry sum, reciprocal
// multiply with tolerance check, remainder correction into the output register.
// rst_n (asynchronous, active low) empties the pipeline and sets the pair and
// triple tolerances to 5 and 7. Depends on rdtm_pkg and the macro header.
`include "robust_depth_trimmed_mean_core_macros.svh"

module robust_depth_trimmed_mean_core
    import rdtm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Window channel
    input  logic                 win_valid,
    output logic                 win_ready,
    input  win_beat_t            win,
    // Result channel
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_beat_t            res,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int STAGES = 6;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  first;
        pixel_t      centre;
    } ctl_t;

    // Configuration registers.
    logic [PAIR_TOL_BITS-1:0]   pair_tol_reg, pair_tol_next;
    logic [TRIPLE_TOL_BITS-1:0] triple_tol_reg, triple_tol_next;
    logic                       cfg_write;

    // Pipeline control.
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] en;

    // Stage payloads.
    window_t               win_masked;
    ctl_t                  ctl_in;
    logic [COUNT_BITS-1:0] count_sat;
    window_t               sort_a_reg, sort_a_next;
    window_t               sort_b_reg, sort_b_next;
    window_t               sort_c_reg, sort_c_next;
    ctl_t                  ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg, ctl_e_reg;
    logic [SUM_BITS-1:0]   sum_d_reg, sum_d_next;
    logic [SUM_BITS-1:0]   target_d_reg, target_d_next;
    logic [SUM_BITS-1:0]   sum_e_reg;
    logic [SUM_BITS-1:0]   q0_e_reg, q0_e_next;
    logic                  kept_e_reg, kept_e_next;
    res_beat_t             res_reg, res_next;

    // Entry selection and arithmetic helpers.
    logic [3:0]                      idx0, idx1, idx2;
    logic [SUM_BITS-1:0]             dev;
    logic [CMP_BITS-1:0]             tol;
    logic [SUM_BITS+RECIP_SHIFT-1:0] prod;
    logic [SUM_BITS-1:0]             rem0;
    logic [SUM_BITS-1:0]             quot;
    logic [SUM_BITS-1:0]             rem;
    logic [FRAC_BITS-1:0]            frac;
    logic [SUM_BITS+FRAC_BITS-1:0]   triple_full;
    logic [SUM_BITS+FRAC_BITS-2:0]   pair_full;
    logic [PIXEL_BITS+FRAC_BITS-1:0] centre_full;

    // Configuration writes and reads; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        pair_tol_next   = pair_tol_reg;
        triple_tol_next = triple_tol_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_PAIR_TOL:   pair_tol_next   = pwdata[PAIR_TOL_BITS-1:0];
                REG_TRIPLE_TOL: triple_tol_next = pwdata[TRIPLE_TOL_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PAIR_TOL:   prdata = DATA_BITS'(pair_tol_reg);
            REG_TRIPLE_TOL: prdata = DATA_BITS'(triple_tol_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pair_tol_reg   <= PAIR_TOL_RESET;
            triple_tol_reg <= TRIPLE_TOL_RESET;
        end else begin
            pair_tol_reg   <= pair_tol_next;
            triple_tol_reg <= triple_tol_next;
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || res_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i + 1];
        end
        vld_next[0] = en[0] ? win_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    assign win_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Input decode: pixels past the count sort to the top as all-ones.
    always_comb
    begin
        count_sat = (win.window_count > COUNT_BITS'(WINDOW_SIZE))
                  ? COUNT_BITS'(WINDOW_SIZE) : win.window_count;
        win_masked[0] = win.pixel_0;
        win_masked[1] = win.pixel_1;
        win_masked[2] = win.pixel_2;
        win_masked[3] = win.pixel_3;
        win_masked[4] = win.pixel_4;
        win_masked[5] = win.pixel_5;
        win_masked[6] = win.pixel_6;
        win_masked[7] = win.pixel_7;
        win_masked[8] = win.pixel_8;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if (COUNT_BITS'(i) >= count_sat) begin
                win_masked[i] = '1;
            end
        end
        ctl_in.centre = win.center_value;
        if (count_sat <= COUNT_BITS'(1)) begin
            ctl_in.mode  = MODE_SINGLE;
            ctl_in.first = 2'd0;
        end else if (count_sat == COUNT_BITS'(2)) begin
            ctl_in.mode  = MODE_PAIR;
            ctl_in.first = 2'd0;
        end else if (count_sat <= COUNT_BITS'(4)) begin
            ctl_in.mode  = MODE_PAIR;
            ctl_in.first = 2'd1;
        end else if (count_sat == COUNT_BITS'(5)) begin
            ctl_in.mode  = MODE_TRIPLE;
            ctl_in.first = 2'd1;
        end else begin
            ctl_in.mode  = MODE_TRIPLE;
            ctl_in.first = 2'd3;
        end
    end

    // Sorting network: nine transposition layers, three per stage.
    assign sort_a_next = sort_layer(sort_layer(sort_layer(win_masked, 1'b0), 1'b1), 1'b0);
    assign sort_b_next = sort_layer(sort_layer(sort_layer(sort_a_reg, 1'b1), 1'b0), 1'b1);
    assign sort_c_next = sort_layer(sort_layer(sort_layer(sort_b_reg, 1'b0), 1'b1), 1'b0);

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            sort_a_reg <= sort_a_next;
            ctl_a_reg  <= ctl_in;
        end
        if (en[1]) begin
            sort_b_reg <= sort_b_next;
            ctl_b_reg  <= ctl_a_reg;
        end
        if (en[2]) begin
            sort_c_reg <= sort_c_next;
            ctl_c_reg  <= ctl_b_reg;
        end
    end

    // Sum of the chosen sorted entries and the centre scaled to match.
    always_comb
    begin
        idx0 = {2'b00, ctl_c_reg.first};
        idx1 = idx0 + 4'd1;
        idx2 = idx0 + 4'd2;
        sum_d_next = SUM_BITS'(sort_c_reg[idx0]) + SUM_BITS'(sort_c_reg[idx1]);
        target_d_next = SUM_BITS'(ctl_c_reg.centre) << 1;
        if (ctl_c_reg.mode == MODE_TRIPLE) begin
            sum_d_next    = sum_d_next + SUM_BITS'(sort_c_reg[idx2]);
            target_d_next = target_d_next + SUM_BITS'(ctl_c_reg.centre);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3]) begin
            sum_d_reg    <= sum_d_next;
            target_d_reg <= target_d_next;
            ctl_d_reg    <= ctl_c_reg;
        end
    end

    // Deviation check, and the sum times the reciprocal of three.
    always_comb
    begin
        dev  = (sum_d_reg >= target_d_reg) ? (sum_d_reg - target_d_reg)
                                           : (target_d_reg - sum_d_reg);
        tol  = (ctl_d_reg.mode == MODE_TRIPLE) ? CMP_BITS'(triple_tol_reg)
                                               : CMP_BITS'(pair_tol_reg);
        kept_e_next = (ctl_d_reg.mode != MODE_SINGLE) && (CMP_BITS'(dev) > tol);
        prod = (SUM_BITS + RECIP_SHIFT)'(sum_d_reg) * (SUM_BITS + RECIP_SHIFT)'(RECIP);
        q0_e_next = prod[SUM_BITS+RECIP_SHIFT-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en[4]) begin
            sum_e_reg  <= sum_d_reg;
            q0_e_reg   <= q0_e_next;
            kept_e_reg <= kept_e_next;
            ctl_e_reg  <= ctl_d_reg;
        end
    end

    // Correct the quotient by one where needed and pick the result.
    always_comb
    begin
        rem0 = sum_e_reg - ((q0_e_reg << 1) + q0_e_reg);
        if (rem0 >= SUM_BITS'(3)) begin
            quot = q0_e_reg + SUM_BITS'(1);
            rem  = rem0 - SUM_BITS'(3);
        end else begin
            quot = q0_e_reg;
            rem  = rem0;
        end
        case (rem)
            SUM_BITS'(1): frac = THIRD_FRAC;
            SUM_BITS'(2): frac = TWO_THIRD_FRAC;
            default:      frac = '0;
        endcase
        triple_full = {quot, frac};
        pair_full   = {sum_e_reg, {(FRAC_BITS - 1){1'b0}}};
        centre_full = {ctl_e_reg.centre, {FRAC_BITS{1'b0}}};

        res_next.kept_center = kept_e_reg;
        if (kept_e_reg || ctl_e_reg.mode == MODE_SINGLE) begin
            res_next.depth_fixed = centre_full[DEPTH_BITS-1:0];
        end else if (ctl_e_reg.mode == MODE_PAIR) begin
            res_next.depth_fixed = pair_full[DEPTH_BITS-1:0];
        end else begin
            res_next.depth_fixed = triple_full[DEPTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5]) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = vld_reg[STAGES-1];
    assign res       = res_reg;

    // Checks on the sorter, the reciprocal divide and the stall logic.
    `RDTM_ASSERT_IMP(a_sorted_window, clk, rst_n, vld_reg[2], is_sorted(sort_c_reg))
    `RDTM_ASSERT_IMP(a_remainder_range, clk, rst_n, vld_reg[4] && ctl_e_reg.mode == MODE_TRIPLE, rem0 < SUM_BITS'(6))
    `RDTM_ASSERT_IMP(a_kept_needs_entries, clk, rst_n, vld_reg[4] && kept_e_reg, ctl_e_reg.mode != MODE_SINGLE)
    `RDTM_ASSERT_NEXT(a_stalled_stage_holds, clk, rst_n, vld_reg[4] && !en[5], vld_reg[4] && $stable(q0_e_reg))

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for robust_depth_trimmed_mean_core: windows go in and
// depth beats come out under random bursts and stalls. Each beat is checked against
// an in-bench trimmed-mean model. Needs rdtm_pkg and the core RTL only.
module tb_top;
    import rdtm_pkg::*;

    localparam int LATENCY     = 6;
    localparam int DRAIN_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 win_valid;
    logic                 win_ready;
    win_beat_t            win;
    logic                 res_valid;
    logic                 res_ready;
    res_beat_t            res;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // The model's copy of the tolerance registers.
    logic [PAIR_TOL_BITS-1:0]   tol_pair;
    logic [TRIPLE_TOL_BITS-1:0] tol_triple;

    // Depth beats that are predicted but not yet seen, oldest first.
    res_beat_t pending_depths[$];

    int mismatches;
    int windows_sent;
    int results_checked;
    int kept_seen;
    int settings_used;
    int burst_left;

    robust_depth_trimmed_mean_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d depth beats still pending", pending_depths.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 40)
        begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Sorts the valid pixels, picks the middle entries, and applies the tolerance test.
    function automatic res_beat_t predict_depth(input win_beat_t w);
        logic [WINDOW_SIZE*PIXEL_BITS-1:0] pix;
        pixel_t      srt [WINDOW_SIZE];
        pixel_t      v;
        int unsigned n;
        int unsigned first;
        int unsigned k;
        int unsigned sum;
        int unsigned target;
        int unsigned dev;
        int unsigned tol;
        int          j;
        mode_t       mode;
        logic [31:0] depth;
        res_beat_t   r;
        pix = {w.pixel_0, w.pixel_1, w.pixel_2, w.pixel_3, w.pixel_4,
               w.pixel_5, w.pixel_6, w.pixel_7, w.pixel_8};
        n = (w.window_count > WINDOW_SIZE) ? WINDOW_SIZE : w.window_count;

        // Insertion sort of the valid pixels only.
        for (int i = 0; i < n; i++)
        begin
            v = pix[(WINDOW_SIZE - 1 - i) * PIXEL_BITS +: PIXEL_BITS];
            j = i;
            while (j > 0 && srt[j - 1] > v)
            begin
                srt[j] = srt[j - 1];
                j--;
            end
            srt[j] = v;
        end

        // Zero or one pixel falls back to the centre; five pixels use the middle three.
        if (n <= 1)
            mode = MODE_SINGLE;
        else if (n <= 4)
            mode = MODE_PAIR;
        else
            mode = MODE_TRIPLE;
        first = (n == 2) ? 0 : ((n <= 5) ? 1 : 3);

        r.kept_center = 1'b0;
        depth = 32'(w.center_value) << FRAC_BITS;
        if (mode != MODE_SINGLE)
        begin
            k = (mode == MODE_PAIR) ? 2 : 3;
            sum = 0;
            for (int i = 0; i < k; i++)
            begin
                sum += srt[first + i];
            end
            target = 32'(w.center_value) * k;
            dev = (sum > target) ? (sum - target) : (target - sum);
            tol = (mode == MODE_PAIR) ? tol_pair : tol_triple;
            if (dev > tol)
                r.kept_center = 1'b1;
            else if (mode == MODE_PAIR)
                depth = sum << (FRAC_BITS - 1);
            else
                depth = (sum << FRAC_BITS) / 3;
        end
        r.depth_fixed = depth[DEPTH_BITS-1:0];
        return r;
    endfunction

    function automatic win_beat_t window_of(input logic [WINDOW_SIZE*PIXEL_BITS-1:0] pix,
                                            input logic [COUNT_BITS-1:0] cnt,
                                            input pixel_t ctr);
        return win_beat_t'({pix, cnt, ctr});
    endfunction

    // Random window: pixels scattered around the centre with a random spread, so that
    // both the averaged and the kept-centre outcomes are common.
    function automatic win_beat_t random_window();
        logic [WINDOW_SIZE*PIXEL_BITS-1:0] pix;
        logic [COUNT_BITS-1:0]             cnt;
        pixel_t                            ctr;
        int                                sel;
        int                                spread;
        int                                v;
        ctr = pixel_t'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 3)
            spread = $urandom_range(0, 3);
        else if (sel < 6)
            spread = $urandom_range(0, 12);
        else if (sel < 8)
            spread = $urandom_range(0, 60);
        else
            spread = 255;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            v = int'(ctr) + $urandom_range(0, 2 * spread) - spread;
            v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            pix[(WINDOW_SIZE - 1 - i) * PIXEL_BITS +: PIXEL_BITS] = pixel_t'(v);
        end
        // Mostly legal counts, with some zero and over-range counts.
        sel = $urandom_range(0, 19);
        if (sel == 0)
            cnt = COUNT_BITS'($urandom_range(10, 15));
        else if (sel == 1)
            cnt = '0;
        else
            cnt = COUNT_BITS'($urandom_range(1, 9));
        return window_of(pix, cnt, ctr);
    endfunction

    // Sends one window beat. The sender runs in bursts with random gaps between them.
    task automatic send_window(input win_beat_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                win_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        win_valid <= 1'b1;
        win       <= w;
        @(posedge clk);
        while (!win_ready)
        begin
            @(posedge clk);
        end
        pending_depths = {pending_depths, predict_depth(w)};
        windows_sent++;
    endtask

    // Holds the sender off until every predicted beat has arrived.
    task automatic wait_for_idle();
        win_valid  <= 1'b0;
        burst_left = 0;
        while (pending_depths.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_PAIR_TOL)
            tol_pair = value[PAIR_TOL_BITS-1:0];
        else
            tol_triple = value[TRIPLE_TOL_BITS-1:0];
        // Leaves the bus idle before the next transfer.
        @(posedge clk);
    endtask

    // Reads a register and compares it with the model's copy.
    task automatic check_register(input logic reg_idx);
        logic [DATA_BITS-1:0] want;
        want = (reg_idx == REG_PAIR_TOL) ? DATA_BITS'(tol_pair) : DATA_BITS'(tol_triple);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            report_mismatch(reg_idx == REG_PAIR_TOL ? "pair_tolerance read"
                                                    : "triple_tolerance read",
                            prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // Leaves the bus idle before the next transfer.
        @(posedge clk);
    endtask

    // Reprograms both tolerances once the pipeline is empty, then reads them back.
    task automatic set_tolerances(input int pair, input int triple);
        wait_for_idle();
        apb_write(REG_PAIR_TOL, DATA_BITS'(pair));
        apb_write(REG_TRIPLE_TOL, DATA_BITS'(triple));
        check_register(REG_PAIR_TOL);
        check_register(REG_TRIPLE_TOL);
        settings_used++;
    endtask

    // A batch of random windows, now and then letting the pipeline run dry.
    task automatic run_random_windows(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_window(random_window());
            if ($urandom_range(0, 149) == 0)
            begin
                wait_for_idle();
            end
        end
    endtask

    task automatic test_register_reset_values();
        check_register(REG_PAIR_TOL);
        check_register(REG_TRIPLE_TOL);
    endtask

    // Field extremes, every window count, and the tolerance edges at reset values.
    task automatic test_directed_windows();
        send_window(window_of({9{8'h00}}, 4'd9, 8'h00));
        send_window(window_of({9{8'hFF}}, 4'd9, 8'hFF));
        send_window(window_of({9{8'h55}}, 4'd0, 8'hAB));
        send_window(window_of({9{8'hFF}}, 4'd1, 8'h00));
        send_window(window_of({9{8'h00}}, 4'd1, 8'hFF));
        // Pair deviation at the tolerance, one past it, and below the centre.
        send_window(window_of({8'd102, 8'd103, {7{8'hC3}}}, 4'd2, 8'd100));
        send_window(window_of({8'd104, 8'd102, {7{8'h3C}}}, 4'd2, 8'd100));
        send_window(window_of({8'd97, 8'd98, {7{8'hFF}}}, 4'd2, 8'd100));
        send_window(window_of({8'd90, 8'd101, 8'd99, {6{8'h00}}}, 4'd3, 8'd100));
        send_window(window_of({8'd200, 8'd10, 8'd101, 8'd103, {5{8'hAA}}}, 4'd4, 8'd100));
        // Five pixels use the middle three entries.
        send_window(window_of({8'd5, 8'd52, 8'd50, 8'd51, 8'd250, {4{8'h11}}}, 4'd5, 8'd50));
        send_window(window_of({8'd5, 8'd60, 8'd50, 8'd51, 8'd250, {4{8'h11}}}, 4'd5, 8'd50));
        send_window(window_of({8'd1, 8'd2, 8'd3, 8'd50, 8'd51, 8'd52, {3{8'hEE}}}, 4'd6,
                              8'd50));
        send_window(window_of({8'd70, 8'd20, 8'd49, 8'd51, 8'd50, 8'd9, 8'd80, 8'hFF,
                               8'hFF}, 4'd7, 8'd50));
        send_window(window_of({8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20,
                               8'h00}, 4'd8, 8'd55));
        // Triple deviation at the tolerance, one past it, and below the centre.
        send_window(window_of({8'd62, 8'd61, 8'd60, 8'd53, 8'd52, 8'd52, 8'd42, 8'd41,
                               8'd40}, 4'd9, 8'd50));
        send_window(window_of({8'd62, 8'd61, 8'd60, 8'd54, 8'd52, 8'd52, 8'd42, 8'd41,
                               8'd40}, 4'd9, 8'd50));
        send_window(window_of({8'd60, 8'd61, 8'd62, 8'd48, 8'd48, 8'd47, 8'd10, 8'd11,
                               8'd12}, 4'd9, 8'd50));
        // Counts above nine saturate.
        send_window(window_of({9{8'd77}}, 4'd10, 8'd77));
        send_window(window_of({8'd1, 8'd9, 8'd2, 8'd8, 8'd3, 8'd7, 8'd4, 8'd6, 8'd5},
                              4'd15, 8'd5));
        send_window(window_of({8'h00, 8'hFF, {7{8'h5A}}}, 4'd2, 8'h7F));
        send_window(window_of({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                               8'h55}, 4'd9, 8'hAA));
        send_window(window_of({8'hFF, 8'hFF, {7{8'h00}}}, 4'd2, 8'h00));
    endtask

    // Zero tolerance keeps all but exact matches; full tolerance keeps nothing.
    task automatic test_tolerance_extremes();
        set_tolerances(0, 0);
        send_window(window_of({8'd40, 8'd40, {7{8'd0}}}, 4'd2, 8'd40));
        send_window(window_of({8'd40, 8'd41, {7{8'd0}}}, 4'd2, 8'd40));
        send_window(window_of({9{8'd33}}, 4'd9, 8'd33));
        run_random_windows(300);
        set_tolerances(510, 765);
        send_window(window_of({8'hFF, 8'hFF, {7{8'h00}}}, 4'd2, 8'h00));
        send_window(window_of({9{8'hFF}}, 4'd9, 8'h00));
        send_window(window_of({9{8'h00}}, 4'd6, 8'hFF));
        run_random_windows(300);
    endtask

    task automatic test_random_tolerances();
        set_tolerances($urandom_range(1, 20), $urandom_range(1, 30));
        run_random_windows(250);
        set_tolerances($urandom_range(0, 510), $urandom_range(0, 765));
        run_random_windows(250);
        set_tolerances($urandom_range(256, 510), $urandom_range(512, 765));
        run_random_windows(250);
    endtask

    // Short batches, each followed by a full drain before the next one starts.
    task automatic test_drain_between_batches();
        set_tolerances($urandom_range(0, 40), $urandom_range(0, 60));
        for (int b = 0; b < 8; b++)
        begin
            run_random_windows($urandom_range(10, 40));
            wait_for_idle();
        end
    endtask

    task automatic test_reset_tolerances_restored();
        set_tolerances(int'(PAIR_TOL_RESET), int'(TRIPLE_TOL_RESET));
        run_random_windows(300);
    endtask

    // The receiver changes its stall behavior every stretch of cycles.
    initial
    begin : stall_pattern
        int mode;
        int stretch;
        int tick;
        res_ready <= 1'b0;
        tick = 0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= ($urandom_range(0, 3) != 0);
                    2: res_ready <= ($urandom_range(0, 2) == 0);
                    default: res_ready <= ((tick % 11) >= 4);
                endcase
            end
        end
    end

    // Compares every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        res_beat_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_depths.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", res.depth_fixed, 0);
            end
            else
            begin
                want = pending_depths.pop_front();
                if (res.depth_fixed !== want.depth_fixed)
                begin
                    report_mismatch("depth_fixed", res.depth_fixed, want.depth_fixed);
                end
                if (res.kept_center !== want.kept_center)
                begin
                    report_mismatch("kept_center", res.kept_center, want.kept_center);
                end
                if (want.kept_center)
                begin
                    kept_seen++;
                end
                results_checked++;
            end
        end
    end

    initial
    begin : main_sequence
        int waited;
        mismatches      = 0;
        windows_sent    = 0;
        results_checked = 0;
        kept_seen       = 0;
        settings_used   = 1;
        burst_left      = 0;
        tol_pair        = PAIR_TOL_RESET;
        tol_triple      = TRIPLE_TOL_RESET;
        rst_n     <= 1'b0;
        win_valid <= 1'b0;
        win       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset_values();
        test_directed_windows();
        test_tolerance_extremes();
        test_random_tolerances();
        test_drain_between_batches();
        test_reset_tolerances_restored();

        // Let the last beats come out, within a bound.
        win_valid <= 1'b0;
        waited = 0;
        while (pending_depths.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 2) @(posedge clk);
        if (pending_depths.size() != 0)
        begin
            report_mismatch("depth beats never delivered", pending_depths.size(), 0);
        end

        $display("Covered %0d windows under %0d tolerance settings with bursty input",
                 windows_sent, settings_used);
        $display("and stalled output: %0d depth beats checked, %0d kept the centre.",
                 results_checked, kept_seen);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
